// ===== src/pcli_pkg.sv =====
`timescale 1ns / 1ps

package pcli_pkg;

    localparam int RAW_BITS_DEF     = 12;
    localparam int POINTS           = 5;
    localparam int SLOT_W           = 3;
    localparam int PCT_W            = 7;
    localparam int CNT_W            = 3;
    localparam int QUO_BITS         = 7;
    localparam int STEP_W           = 3;
    localparam int MAX_RAW_RESET    = 4095;
    localparam int PCT_SCALE        = 100;
    localparam int MIN_TABLE_POINTS = 2;
    localparam int OUT_BITS         = PCT_W + CNT_W + 1;
    localparam int OUT_TDATA_W      = ((OUT_BITS + 7) / 8) * 8;

    localparam logic CMD_CAPTURE = 1'b1;

    typedef enum logic [0:0] {
        REG_MIN_RAW = 1'b0,
        REG_MAX_RAW = 1'b1
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SETUP,
        ST_MUL_A,
        ST_MUL_B,
        ST_LOAD,
        ST_DIV,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic              accept;
        logic              scan;
        logic              setup;
        logic              mul_a;
        logic              mul_b;
        logic              load;
        logic              div;
        logic              out_load;
        logic [STEP_W-1:0] step;
    } dp_cmd_t;

    typedef struct packed {
        logic direct;
    } dp_stat_t;

    function automatic logic [PCT_W-1:0] slot_target(input logic [SLOT_W-1:0] s);
        logic [PCT_W-1:0] t;
        case (s)
            3'd0:    t = 7'd0;
            3'd1:    t = 7'd25;
            3'd2:    t = 7'd50;
            3'd3:    t = 7'd75;
            3'd4:    t = 7'd100;
            default: t = 7'd0;
        endcase
        return t;
    endfunction

endpackage

// ===== src/pcli_ctrl.sv =====
`timescale 1ns / 1ps

module pcli_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    output pcli_pkg::dp_cmd_t  cmd,
    input  pcli_pkg::dp_stat_t stat
);
    import pcli_pkg::*;

    state_t            state_reg;
    state_t            state_next;
    logic [STEP_W-1:0] cnt_reg;
    logic [STEP_W-1:0] cnt_next;
    logic              out_valid_reg;
    logic              out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_SCAN;
                    cnt_next   = '0;
                end
            end
            ST_SCAN:
            begin
                if (cnt_reg == STEP_W'(POINTS - 1))
                begin
                    state_next = ST_SETUP;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_SETUP:
            begin
                state_next = stat.direct ? ST_DONE : ST_MUL_A;
            end
            ST_MUL_A:
            begin
                state_next = ST_MUL_B;
            end
            ST_MUL_B:
            begin
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                state_next = ST_DIV;
                cnt_next   = STEP_W'(QUO_BITS - 1);
            end
            ST_DIV:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                // no transfer while held in reset
                in_ready   = rst_n;
                cmd.accept = in_valid && rst_n;
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                cmd.step = cnt_reg;
            end
            ST_SETUP:
            begin
                cmd.setup = 1'b1;
            end
            ST_MUL_A:
            begin
                cmd.mul_a = 1'b1;
            end
            ST_MUL_B:
            begin
                cmd.mul_b = 1'b1;
            end
            ST_LOAD:
            begin
                cmd.load = 1'b1;
            end
            ST_DIV:
            begin
                cmd.div  = 1'b1;
                cmd.step = cnt_reg;
            end
            ST_DONE:
            begin
                cmd.out_load = !out_valid_reg || out_ready;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_comb
    begin
        priority if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// ===== src/pcli_dp.sv =====
`timescale 1ns / 1ps

module pcli_dp #(
    parameter int RAW_BITS = pcli_pkg::RAW_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  pcli_pkg::dp_cmd_t            cmd,
    output pcli_pkg::dp_stat_t           stat,
    input  logic                         cfg_we,
    input  pcli_pkg::reg_idx_t           cfg_addr,
    input  logic [RAW_BITS-1:0]          cfg_data,
    input  logic                         in_command,
    input  logic [RAW_BITS-1:0]          in_raw,
    input  logic [pcli_pkg::SLOT_W-1:0]  in_slot,
    output logic [pcli_pkg::PCT_W-1:0]   percent,
    output logic [pcli_pkg::CNT_W-1:0]   point_count,
    output logic                         table_in_use
);
    import pcli_pkg::*;

    localparam int PROD_W = RAW_BITS + 9;
    localparam int SUM_W  = RAW_BITS + 10;
    localparam int NUM_W  = RAW_BITS + 9;
    localparam int DIV_W  = RAW_BITS + 1;

    logic [RAW_BITS-1:0] cfg_min_reg;
    logic [RAW_BITS-1:0] cfg_max_reg;

    logic [RAW_BITS-1:0] raw_reg;
    logic [RAW_BITS-1:0] slot_raw_reg [POINTS];
    logic [POINTS-1:0]   slot_used_reg;

    logic                min_ok_reg;
    logic [RAW_BITS-1:0] min_raw_reg;
    logic [SLOT_W-1:0]   min_slot_reg;
    logic                max_ok_reg;
    logic [RAW_BITS-1:0] max_raw_reg;
    logic [SLOT_W-1:0]   max_slot_reg;
    logic                lo_ok_reg;
    logic [RAW_BITS-1:0] lo_raw_reg;
    logic [SLOT_W-1:0]   lo_slot_reg;
    logic                hi_ok_reg;
    logic [RAW_BITS-1:0] hi_raw_reg;
    logic [SLOT_W-1:0]   hi_slot_reg;

    logic                interp_reg;
    logic [RAW_BITS-1:0] opa_reg;
    logic signed [7:0]   opb_reg;
    logic [RAW_BITS-1:0] den_reg;
    logic [PCT_W-1:0]    y0_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] acc_reg;
    logic [NUM_W-1:0]    rem_reg;
    logic [DIV_W-1:0]    div_reg;
    logic [PCT_W-1:0]    res_reg;

    logic [PCT_W-1:0]    percent_reg;
    logic [CNT_W-1:0]    count_reg;
    logic                in_use_reg;

    logic [CNT_W-1:0]    cnt;
    logic [RAW_BITS-1:0] cur_raw;
    logic                cur_used;
    logic                upd_min;
    logic                upd_max;
    logic                upd_lo;
    logic                upd_hi;

    logic                direct;
    logic [PCT_W-1:0]    direct_pct;
    logic                setup_interp;
    logic [RAW_BITS-1:0] setup_a;
    logic signed [7:0]   setup_b;
    logic [RAW_BITS-1:0] setup_den;
    logic [PCT_W-1:0]    setup_y0;
    logic [RAW_BITS-1:0] clamp_raw;
    logic [PCT_W-1:0]    hi_pct;

    logic [RAW_BITS-1:0] mul_a;
    logic signed [7:0]   mul_b;
    logic signed [PROD_W-1:0] product;
    logic signed [SUM_W-1:0]  sum;
    logic [SUM_W-1:0]    num_wide;
    logic [NUM_W-1:0]    shifted;
    logic                capture;

    always_comb
    begin
        cnt = '0;
        for (int i = 0; i < POINTS; i++)
        begin
            cnt = cnt + CNT_W'(slot_used_reg[i]);
        end
    end

    assign capture = cmd.accept && (in_command == CMD_CAPTURE)
                     && (in_slot < SLOT_W'(POINTS));

    // serial scan over the slots keeps table order: raw first, then slot
    assign cur_raw  = slot_raw_reg[cmd.step];
    assign cur_used = slot_used_reg[cmd.step];
    assign upd_min  = cur_used && (!min_ok_reg || (cur_raw < min_raw_reg));
    assign upd_max  = cur_used && (!max_ok_reg || (cur_raw >= max_raw_reg));
    assign upd_lo   = cur_used && (cur_raw < raw_reg)
                      && (!lo_ok_reg || (cur_raw >= lo_raw_reg));
    assign upd_hi   = cur_used && (cur_raw >= raw_reg)
                      && (!hi_ok_reg || (cur_raw < hi_raw_reg));

    always_comb
    begin
        direct       = 1'b0;
        direct_pct   = '0;
        setup_interp = 1'b0;
        setup_a      = '0;
        setup_b      = '0;
        setup_den    = '0;
        setup_y0     = '0;
        clamp_raw    = raw_reg;
        hi_pct       = slot_target(hi_slot_reg);
        priority if (cnt < CNT_W'(MIN_TABLE_POINTS))
        begin
            if (cfg_max_reg <= cfg_min_reg)
            begin
                direct = 1'b1;
            end
            else
            begin
                priority if (raw_reg < cfg_min_reg)
                begin
                    clamp_raw = cfg_min_reg;
                end
                else if (raw_reg > cfg_max_reg)
                begin
                    clamp_raw = cfg_max_reg;
                end
                else
                begin
                    clamp_raw = raw_reg;
                end
                setup_a   = clamp_raw - cfg_min_reg;
                setup_b   = 8'(PCT_SCALE);
                setup_den = cfg_max_reg - cfg_min_reg;
            end
        end
        else if (raw_reg <= min_raw_reg)
        begin
            direct     = 1'b1;
            direct_pct = slot_target(min_slot_reg);
        end
        else if (raw_reg >= max_raw_reg)
        begin
            direct     = 1'b1;
            direct_pct = slot_target(max_slot_reg);
        end
        else
        begin
            setup_interp = 1'b1;
            setup_a      = raw_reg - lo_raw_reg;
            setup_den    = hi_raw_reg - lo_raw_reg;
            setup_y0     = slot_target(lo_slot_reg);
            setup_b      = $signed({1'b0, hi_pct}) - $signed({1'b0, setup_y0});
        end
    end

    assign stat.direct = direct;

    assign mul_a   = cmd.mul_b ? (interp_reg ? den_reg : '0) : opa_reg;
    assign mul_b   = cmd.mul_b ? $signed({1'b0, y0_reg}) : opb_reg;
    assign product = PROD_W'($signed({1'b0, mul_a})) * PROD_W'(mul_b);

    assign sum      = SUM_W'(acc_reg) + SUM_W'(prod_reg);
    assign num_wide = interp_reg ? ((unsigned'(sum) << 1) + SUM_W'(den_reg))
                                 : unsigned'(sum);
    assign shifted  = NUM_W'(div_reg) << cmd.step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_min_reg   <= '0;
            cfg_max_reg   <= RAW_BITS'(MAX_RAW_RESET);
            slot_used_reg <= '0;
            min_ok_reg    <= 1'b0;
            max_ok_reg    <= 1'b0;
            lo_ok_reg     <= 1'b0;
            hi_ok_reg     <= 1'b0;
            interp_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_addr)
                    REG_MIN_RAW: cfg_min_reg <= cfg_data;
                    REG_MAX_RAW: cfg_max_reg <= cfg_data;
                    default:     cfg_min_reg <= cfg_min_reg;
                endcase
            end
            if (capture)
            begin
                slot_used_reg[in_slot] <= 1'b1;
            end
            if (cmd.accept)
            begin
                min_ok_reg <= 1'b0;
                max_ok_reg <= 1'b0;
                lo_ok_reg  <= 1'b0;
                hi_ok_reg  <= 1'b0;
            end
            if (cmd.scan)
            begin
                if (upd_min)
                begin
                    min_ok_reg <= 1'b1;
                end
                if (upd_max)
                begin
                    max_ok_reg <= 1'b1;
                end
                if (upd_lo)
                begin
                    lo_ok_reg <= 1'b1;
                end
                if (upd_hi)
                begin
                    hi_ok_reg <= 1'b1;
                end
            end
            if (cmd.setup)
            begin
                interp_reg <= setup_interp;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            raw_reg <= in_raw;
        end
        if (capture)
        begin
            slot_raw_reg[in_slot] <= in_raw;
        end
        if (cmd.scan)
        begin
            if (upd_min)
            begin
                min_raw_reg  <= cur_raw;
                min_slot_reg <= cmd.step;
            end
            if (upd_max)
            begin
                max_raw_reg  <= cur_raw;
                max_slot_reg <= cmd.step;
            end
            if (upd_lo)
            begin
                lo_raw_reg  <= cur_raw;
                lo_slot_reg <= cmd.step;
            end
            if (upd_hi)
            begin
                hi_raw_reg  <= cur_raw;
                hi_slot_reg <= cmd.step;
            end
        end
        if (cmd.setup)
        begin
            res_reg <= direct_pct;
            opa_reg <= setup_a;
            opb_reg <= setup_b;
            den_reg <= setup_den;
            y0_reg  <= setup_y0;
        end
        if (cmd.mul_a)
        begin
            prod_reg <= product;
        end
        if (cmd.mul_b)
        begin
            acc_reg  <= prod_reg;
            prod_reg <= product;
        end
        if (cmd.load)
        begin
            rem_reg <= num_wide[NUM_W-1:0];
            div_reg <= interp_reg ? {den_reg, 1'b0} : {1'b0, den_reg};
            res_reg <= '0;
        end
        if (cmd.div && (rem_reg >= shifted))
        begin
            rem_reg           <= rem_reg - shifted;
            res_reg[cmd.step] <= 1'b1;
        end
        if (cmd.out_load)
        begin
            percent_reg <= res_reg;
            count_reg   <= cnt;
            in_use_reg  <= (cnt >= CNT_W'(MIN_TABLE_POINTS));
        end
    end

    assign percent      = percent_reg;
    assign point_count  = count_reg;
    assign table_in_use = in_use_reg;

endmodule

// ===== src/pot_calibration_lut_interpolator_core.sv =====
`timescale 1ns / 1ps
// sequence: slot scan and setup, then two passes of the shared multiplier and the restoring
// divider when interpolating or on the fallback line; setup loads the result directly when the
// reading clamps to a table end point or the range is empty
// input: a new item is accepted only when idle, after the last result is loaded for output
// reset: asynchronous active low; clears the slot table, min_raw to 0, max_raw to 4095

module pot_calibration_lut_interpolator_core #(
    parameter int  RAW_BITS   = pcli_pkg::RAW_BITS_DEF,
    localparam int IN_BITS    = RAW_BITS + 4,
    localparam int IN_TDATA_W = ((IN_BITS + 7) / 8) * 8
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  pcli_pkg::reg_idx_t                 cfg_addr,
    input  logic [RAW_BITS-1:0]                cfg_data,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [IN_TDATA_W-1:0]              s_axis_tdata,  // command, raw, slot
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [pcli_pkg::OUT_TDATA_W-1:0]   m_axis_tdata   // percent, point_count, table_in_use
);
    import pcli_pkg::*;

    dp_cmd_t           cmd;
    dp_stat_t          stat;
    logic [PCT_W-1:0]  percent;
    logic [CNT_W-1:0]  point_count;
    logic              table_in_use;

    pcli_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .cmd       (cmd),
        .stat      (stat)
    );

    pcli_dp #(
        .RAW_BITS (RAW_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .cfg_we       (cfg_we),
        .cfg_addr     (cfg_addr),
        .cfg_data     (cfg_data),
        .in_command   (s_axis_tdata[0]),
        .in_raw       (s_axis_tdata[RAW_BITS:1]),
        .in_slot      (s_axis_tdata[RAW_BITS+SLOT_W:RAW_BITS+1]),
        .percent      (percent),
        .point_count  (point_count),
        .table_in_use (table_in_use)
    );

    assign m_axis_tdata = {{(OUT_TDATA_W - OUT_BITS){1'b0}}, table_in_use, point_count, percent};

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import pcli_pkg::*;

    localparam int RAW_W = RAW_BITS_DEF;
    localparam int IN_W = 16;
    localparam logic CMD_CONVERT = 1'b0;
    localparam logic [PCT_W-1:0] TARGET_PCT [0:POINTS-1] = '{7'd0, 7'd25, 7'd50, 7'd75, 7'd100};

    localparam int PLAN_LEN = 34;
    localparam int FALLBACK_AT = 19;
    localparam int FALLBACK_PHASES = 6;
    localparam int FALLBACK_ITEMS = 40;
    localparam int TABLE_PHASES = 5;
    localparam int TABLE_ITEMS = 270;
    localparam int LONG_HOLD = 300;
    localparam int SETTLE_CYCLES = 24;

    typedef struct packed {
        logic [PCT_W-1:0] pct;
        logic [CNT_W-1:0] cnt;
        logic             used;
    } reading_t;

    typedef enum logic [1:0] {
        ROW_ITEM,
        ROW_SET_MIN,
        ROW_SET_MAX
    } row_kind_t;

    typedef struct {
        row_kind_t         kind;
        logic              cmd;
        logic [RAW_W-1:0]  raw;
        logic [SLOT_W-1:0] slot;
        bit                typed;
        reading_t          want;
    } plan_row_t;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_we;
    reg_idx_t               cfg_addr;
    logic [RAW_W-1:0]       cfg_data;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_W-1:0]        s_axis_tdata;   // command, raw, slot
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;   // percent, point_count, table_in_use

    logic [RAW_W-1:0] lo_bound;
    logic [RAW_W-1:0] hi_bound;
    logic [RAW_W-1:0] pt_raw [0:POINTS-1];
    logic [PCT_W-1:0] pt_pct [0:POINTS-1];
    int               pt_count;
    bit               slot_taken [0:POINTS-1];

    reading_t pending_readings [$];
    int       mismatches = 0;
    bit       calm = 1'b0;
    bit       long_hold = 1'b0;

    pot_calibration_lut_interpolator_core DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void apply_capture(input logic [RAW_W-1:0] raw,
                                          input logic [SLOT_W-1:0] slot);
        logic [RAW_W-1:0] sr [0:POINTS-1];
        logic [PCT_W-1:0] sp [0:POINTS-1];
        logic [RAW_W-1:0] kr;
        logic [PCT_W-1:0] kp;
        int n;
        int i;
        int j;
        int s;
        bit hit;
        n = 0;
        hit = 1'b0;
        if (slot >= POINTS)
            return;
        slot_taken[slot] = 1'b1;
        for (i = 0; i < pt_count; i++)
        begin
            if (!hit && pt_pct[i] == TARGET_PCT[slot])
            begin
                pt_raw[i] = raw;
                hit = 1'b1;
            end
        end
        if (!hit && pt_count < POINTS)
        begin
            pt_raw[pt_count] = raw;
            pt_pct[pt_count] = TARGET_PCT[slot];
            pt_count++;
        end
        // rebuild in slot order, then stable sort by raw
        for (s = 0; s < POINTS; s++)
        begin
            hit = 1'b0;
            if (slot_taken[s])
            begin
                for (i = 0; i < pt_count; i++)
                begin
                    if (!hit && pt_pct[i] == TARGET_PCT[s])
                    begin
                        sr[n] = pt_raw[i];
                        sp[n] = pt_pct[i];
                        n++;
                        hit = 1'b1;
                    end
                end
            end
        end
        if (n < MIN_TABLE_POINTS)
            return;
        for (i = 1; i < n; i++)
        begin
            kr = sr[i];
            kp = sp[i];
            j = i;
            while (j > 0 && sr[j-1] > kr)
            begin
                sr[j] = sr[j-1];
                sp[j] = sp[j-1];
                j--;
            end
            sr[j] = kr;
            sp[j] = kp;
        end
        pt_count = n;
        for (i = 0; i < n; i++)
        begin
            pt_raw[i] = sr[i];
            pt_pct[i] = sp[i];
        end
    endfunction

    function automatic logic [PCT_W-1:0] percent_of(input logic [RAW_W-1:0] raw);
        longint lo;
        longint hi;
        longint r;
        longint x0;
        longint x1;
        longint y0;
        longint y1;
        longint den;
        longint num;
        longint q;
        int i;
        r = raw;
        if (pt_count < MIN_TABLE_POINTS)
        begin
            lo = lo_bound;
            hi = hi_bound;
            if (hi <= lo)
                return '0;
            if (r < lo)
                r = lo;
            if (r > hi)
                r = hi;
            q = ((r - lo) * PCT_SCALE) / (hi - lo);
            return PCT_W'((q > PCT_SCALE) ? PCT_SCALE : q);
        end
        if (raw <= pt_raw[0])
            return pt_pct[0];
        if (raw >= pt_raw[pt_count-1])
            return pt_pct[pt_count-1];
        for (i = 0; i < pt_count - 1; i++)
        begin
            x0 = pt_raw[i];
            x1 = pt_raw[i+1];
            if (r >= x0 && r <= x1)
            begin
                y0 = pt_pct[i];
                y1 = pt_pct[i+1];
                den = x1 - x0;
                if (den <= 0)
                    return PCT_W'((y0 > PCT_SCALE) ? PCT_SCALE : y0);
                num = 2 * y0 * den + 2 * (r - x0) * (y1 - y0) + den;
                if (num < 0)
                    return '0;
                q = num / (2 * den);
                return PCT_W'((q > PCT_SCALE) ? PCT_SCALE : q);
            end
        end
        return '0;
    endfunction

    function automatic reading_t predict_reading(input logic cmd,
                                                 input logic [RAW_W-1:0] raw,
                                                 input logic [SLOT_W-1:0] slot);
        reading_t r;
        if (cmd == CMD_CAPTURE)
            apply_capture(raw, slot);
        r.pct = percent_of(raw);
        r.cnt = CNT_W'(pt_count);
        r.used = (pt_count >= MIN_TABLE_POINTS);
        return r;
    endfunction

    task automatic send_item(input logic cmd, input logic [RAW_W-1:0] raw,
                             input logic [SLOT_W-1:0] slot, input bit typed,
                             input reading_t want);
        reading_t forecast;
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {slot, raw, cmd};
        do @(posedge clk); while (!s_axis_tready);
        forecast = predict_reading(cmd, raw, slot);
        pending_readings.push_back(typed ? want : forecast);
        @(negedge clk);
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (pending_readings.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic set_register(input reg_idx_t idx, input logic [RAW_W-1:0] value);
        wait_idle();
        cfg_we   <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_MIN_RAW)
            lo_bound = value;
        else
            hi_bound = value;
    endtask

    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (long_hold)
            begin
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
                long_hold = 1'b0;
                m_axis_tready <= 1'b1;
            end
            else if (!calm && $urandom_range(0, 7) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(negedge clk);
                m_axis_tready <= 1'b1;
            end
            else
            begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        reading_t seen;
        reading_t owed;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            seen.pct  = m_axis_tdata[PCT_W-1:0];
            seen.cnt  = m_axis_tdata[PCT_W+CNT_W-1:PCT_W];
            seen.used = m_axis_tdata[PCT_W+CNT_W];
            if (pending_readings.size() == 0)
            begin
                $display("%0t: transfer with nothing expected, tdata %h", $time, m_axis_tdata);
                mismatches++;
            end
            else
            begin
                owed = pending_readings.pop_front();
                if (seen.pct !== owed.pct)
                begin
                    $display("%0t: percent expected %0d actual %0d",
                             $time, owed.pct, seen.pct);
                    mismatches++;
                end
                if (seen.cnt !== owed.cnt)
                begin
                    $display("%0t: point_count expected %0d actual %0d",
                             $time, owed.cnt, seen.cnt);
                    mismatches++;
                end
                if (seen.used !== owed.used)
                begin
                    $display("%0t: table_in_use expected %0d actual %0d",
                             $time, owed.used, seen.used);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("tb: errors");
        $finish;
    end

    initial
    begin
        plan_row_t plan [PLAN_LEN];
        logic cmd;
        logic [RAW_W-1:0] raw;
        logic [RAW_W-1:0] lo_pick;
        logic [RAW_W-1:0] hi_pick;
        logic [SLOT_W-1:0] slot;
        int near;
        int i;
        int p;
        int j;

        plan = '{
            '{ROW_SET_MIN, CMD_CONVERT, 12'd0,    3'd0, 1'b0, '0},
            '{ROW_SET_MAX, CMD_CONVERT, 12'd4095, 3'd0, 1'b0, '0},
            '{ROW_ITEM,    CMD_CONVERT, 12'd0,    3'd0, 1'b1, '{7'd0,   3'd0, 1'b0}},
            '{ROW_ITEM,    CMD_CONVERT, 12'd4095, 3'd7, 1'b1, '{7'd100, 3'd0, 1'b0}},
            '{ROW_ITEM,    CMD_CONVERT, 12'd2048, 3'd2, 1'b0, '0},
            '{ROW_SET_MIN, CMD_CONVERT, 12'd1000, 3'd0, 1'b0, '0},
            '{ROW_SET_MAX, CMD_CONVERT, 12'd3000, 3'd0, 1'b0, '0},
            '{ROW_ITEM,    CMD_CONVERT, 12'd500,  3'd0, 1'b1, '{7'd0,   3'd0, 1'b0}},
            '{ROW_ITEM,    CMD_CONVERT, 12'd3500, 3'd0, 1'b1, '{7'd100, 3'd0, 1'b0}},
            '{ROW_ITEM,    CMD_CONVERT, 12'd2000, 3'd0, 1'b1, '{7'd50,  3'd0, 1'b0}},
            // empty fallback range
            '{ROW_SET_MIN, CMD_CONVERT, 12'd2000, 3'd0, 1'b0, '0},
            '{ROW_SET_MAX, CMD_CONVERT, 12'd2000, 3'd0, 1'b0, '0},
            '{ROW_ITEM,    CMD_CONVERT, 12'd2000, 3'd0, 1'b1, '{7'd0,   3'd0, 1'b0}},
            '{ROW_SET_MIN, CMD_CONVERT, 12'd4095, 3'd0, 1'b0, '0},
            '{ROW_SET_MAX, CMD_CONVERT, 12'd0,    3'd0, 1'b0, '0},
            '{ROW_ITEM,    CMD_CONVERT, 12'd4095, 3'd0, 1'b1, '{7'd0,   3'd0, 1'b0}},
            // slot out of range
            '{ROW_ITEM,    CMD_CAPTURE, 12'd123,  3'd5, 1'b1, '{7'd0,   3'd0, 1'b0}},
            '{ROW_ITEM,    CMD_CAPTURE, 12'd4095, 3'd7, 1'b1, '{7'd0,   3'd0, 1'b0}},
            // single point, still on the fallback line
            '{ROW_ITEM,    CMD_CAPTURE, 12'd4095, 3'd0, 1'b1, '{7'd0,   3'd1, 1'b0}},
            '{ROW_SET_MIN, CMD_CONVERT, 12'd0,    3'd0, 1'b0, '0},
            '{ROW_SET_MAX, CMD_CONVERT, 12'd4095, 3'd0, 1'b0, '0},
            '{ROW_ITEM,    CMD_CONVERT, 12'd4095, 3'd0, 1'b1, '{7'd100, 3'd1, 1'b0}},
            '{ROW_ITEM,    CMD_CAPTURE, 12'd0,    3'd4, 1'b1, '{7'd100, 3'd2, 1'b1}},
            '{ROW_ITEM,    CMD_CONVERT, 12'd4095, 3'd0, 1'b1, '{7'd0,   3'd2, 1'b1}},
            '{ROW_ITEM,    CMD_CONVERT, 12'd2048, 3'd0, 1'b0, '0},
            '{ROW_ITEM,    CMD_CAPTURE, 12'd2048, 3'd2, 1'b0, '0},
            '{ROW_ITEM,    CMD_CAPTURE, 12'd3000, 3'd1, 1'b0, '0},
            '{ROW_ITEM,    CMD_CAPTURE, 12'd1000, 3'd3, 1'b0, '0},
            // repeated capture moves a point
            '{ROW_ITEM,    CMD_CAPTURE, 12'd2500, 3'd2, 1'b0, '0},
            '{ROW_ITEM,    CMD_CAPTURE, 12'd10,   3'd6, 1'b0, '0},
            '{ROW_ITEM,    CMD_CONVERT, 12'd1,    3'd0, 1'b0, '0},
            '{ROW_ITEM,    CMD_CONVERT, 12'd4094, 3'd0, 1'b0, '0},
            '{ROW_ITEM,    CMD_CAPTURE, 12'd2500, 3'd3, 1'b0, '0},
            '{ROW_ITEM,    CMD_CONVERT, 12'd2500, 3'd0, 1'b0, '0}
        };

        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_addr      = REG_MIN_RAW;
        cfg_data      = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        lo_bound      = '0;
        hi_bound      = RAW_W'(MAX_RAW_RESET);
        pt_count      = 0;
        for (i = 0; i < POINTS; i++)
        begin
            pt_raw[i]     = '0;
            pt_pct[i]     = '0;
            slot_taken[i] = 1'b0;
        end
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (i = 0; i < PLAN_LEN; i++)
        begin
            if (i == FALLBACK_AT)
            begin
                // fallback line under assorted bounds, table stays below two points
                for (p = 0; p < FALLBACK_PHASES; p++)
                begin
                    case (p)
                        0:
                        begin
                            lo_pick = '0;
                            hi_pick = 12'd1;
                        end
                        1:
                        begin
                            lo_pick = 12'd4094;
                            hi_pick = '1;
                        end
                        2:
                        begin
                            lo_pick = RAW_W'($urandom_range(0, 4095));
                            hi_pick = lo_pick;
                        end
                        3:
                        begin
                            hi_pick = RAW_W'($urandom_range(0, 4094));
                            lo_pick = RAW_W'($urandom_range(hi_pick + 1, 4095));
                        end
                        default:
                        begin
                            lo_pick = RAW_W'($urandom_range(0, 2047));
                            hi_pick = RAW_W'($urandom_range(2048, 4095));
                        end
                    endcase
                    set_register(REG_MIN_RAW, lo_pick);
                    set_register(REG_MAX_RAW, hi_pick);
                    for (j = 0; j < FALLBACK_ITEMS; j++)
                    begin
                        cmd = 1'($urandom_range(0, 1));
                        if (cmd == CMD_CAPTURE)
                            slot = SLOT_W'($urandom_range(5, 7));
                        else
                            slot = SLOT_W'($urandom_range(0, 7));
                        case ($urandom_range(0, 4))
                            0:       raw = lo_bound;
                            1:       raw = hi_bound;
                            2:       raw = '0;
                            3:       raw = '1;
                            default: raw = RAW_W'($urandom_range(0, 4095));
                        endcase
                        send_item(cmd, raw, slot, 1'b0, '0);
                    end
                end
            end
            case (plan[i].kind)
                ROW_SET_MIN: set_register(REG_MIN_RAW, plan[i].raw);
                ROW_SET_MAX: set_register(REG_MAX_RAW, plan[i].raw);
                default:     send_item(plan[i].cmd, plan[i].raw, plan[i].slot,
                                       plan[i].typed, plan[i].want);
            endcase
        end

        for (p = 0; p < TABLE_PHASES; p++)
        begin
            set_register(REG_MIN_RAW, RAW_W'($urandom_range(0, 4095)));
            set_register(REG_MAX_RAW, RAW_W'($urandom_range(0, 4095)));
            if (p == 1)
                long_hold = 1'b1;
            if (p == TABLE_PHASES - 1)
                calm = 1'b1;
            for (j = 0; j < TABLE_ITEMS; j++)
            begin
                cmd = ($urandom_range(0, 3) == 0) ? CMD_CAPTURE : CMD_CONVERT;
                if (cmd == CMD_CAPTURE)
                    slot = ($urandom_range(0, 7) == 0) ? SLOT_W'($urandom_range(5, 7))
                                                      : SLOT_W'($urandom_range(0, 4));
                else
                    slot = SLOT_W'($urandom_range(0, 7));
                case ($urandom_range(0, 5))
                    0:       raw = '0;
                    1:       raw = '1;
                    2, 3:
                    begin
                        // land on or next to a calibration point
                        near = int'(pt_raw[$urandom_range(0, pt_count - 1)])
                               + int'($urandom_range(0, 2)) - 1;
                        if (near < 0)
                            near = 0;
                        if (near > 4095)
                            near = 4095;
                        raw = near[RAW_W-1:0];
                    end
                    default: raw = RAW_W'($urandom_range(0, 4095));
                endcase
                send_item(cmd, raw, slot, 1'b0, '0);
            end
        end

        wait_idle();
        repeat (20) @(negedge clk);
        if (mismatches == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule
